[hdl/wcw_pkg.sv]
// package for the westwood congestion window block
// holds shared constants, datapath command and status types; no dependencies
`timescale 1ns / 1ps

package wcw_pkg;

    localparam logic [31:0] TICKS_PER_SECOND = 32'd1000;
    localparam logic [31:0] AVERAGE_WEIGHT   = 32'd8;

    localparam logic [31:0] WINDOW_RESET    = 32'd10;
    localparam logic [31:0] THRESHOLD_RESET = 32'h7FFF_FFFF;
    localparam logic [31:0] NO_RTT          = 32'hFFFF_FFFF;
    localparam logic [31:0] BW_RESET        = 32'd100;
    localparam logic [15:0] SEGMENT_RESET   = 16'd1460;
    localparam logic [31:0] MIN_WINDOW      = 32'd2;

    localparam logic [1:0] ACT_ACK    = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_LOSS   = 2'd2;
    localparam logic [1:0] ACT_SET    = 2'd3;

    localparam int DIV_W   = 32;
    localparam int DIV_CNT = $clog2(DIV_W + 1);

    // division operand selects
    typedef enum logic [1:0] {
        DSEL_RATE,
        DSEL_GROW,
        DSEL_LOSS
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     ack_pre;
        logic     div_start;
        div_sel_t div_sel;
        logic     rate_done;
        logic     grow_done;
        logic     grow_add;
        logic     loss_done;
        logic     loss_half;
        logic     set_done;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       take_rate;
        logic       slow_start;
        logic       loss_est;
        logic       div_busy;
    } dp_status_t;

endpackage

[hdl/wcw_divider.sv]
// restoring divider, one quotient bit per cycle
// depends on wcw_pkg
`timescale 1ns / 1ps

module wcw_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);
    import wcw_pkg::*;

    logic [DIV_W-1:0]   quo_reg;
    logic [DIV_W:0]     rem_reg;
    logic [DIV_W-1:0]   dsr_reg;
    logic [DIV_CNT-1:0] cnt_reg;
    logic               busy_reg;
    logic [DIV_W:0]     trial;
    logic [DIV_W:0]     diff;

    assign trial    = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
    assign diff     = trial - {1'b0, dsr_reg};
    assign busy     = busy_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT'(DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_W])
            begin
                rem_reg <= diff;
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

endmodule

[hdl/wcw_datapath.sv]
// datapath: connection state, multipliers, shared divider, result registers
// depends on wcw_pkg and wcw_divider
`timescale 1ns / 1ps

module wcw_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  wcw_pkg::dp_cmd_t    cmd,
    output wcw_pkg::dp_status_t status,
    input  logic [15:0]         mss,
    input  logic [1:0]          action,
    input  logic [31:0]         new_bytes,
    input  logic [63:0]         cur_tick,
    input  logic [31:0]         rtt_sample,
    input  logic [15:0]         new_segments,
    input  logic [31:0]         cwnd_in,
    output logic [31:0]         cwnd_out,
    output logic [31:0]         ssthresh_out,
    output logic [31:0]         bw_estimate
);
    import wcw_pkg::*;

    logic [1:0]  act_reg;
    logic [31:0] bytes_reg;
    logic [63:0] now_reg;
    logic [31:0] rtt_reg;
    logic [15:0] segs_reg;
    logic [31:0] cw_reg;

    logic [31:0] window_reg;
    logic [31:0] thresh_reg;
    logic [31:0] minrtt_reg;
    logic [31:0] bw_reg;
    logic [63:0] last_reg;
    logic        have_reg;

    logic [31:0] num_reg;
    logic [31:0] span_reg;
    logic        take_reg;
    logic        est_reg;

    logic [31:0] cwnd_out_reg;
    logic [31:0] thresh_out_reg;
    logic [31:0] bw_out_reg;

    logic [63:0] span64;
    logic [31:0] span;
    logic [31:0] cw_nz;
    logic [31:0] div_a;
    logic [31:0] div_b;
    logic        div_busy;
    logic [31:0] quo;
    logic [31:0] acc;
    logic [31:0] grown;

    assign span64 = now_reg - last_reg;
    assign span   = span64[31:0];
    assign cw_nz  = (cw_reg == '0) ? 32'd1 : cw_reg;

    always_comb
    begin
        case (cmd.div_sel)
            DSEL_RATE:
            begin
                div_a = num_reg;
                div_b = span_reg;
            end
            DSEL_GROW:
            begin
                div_a = {16'd0, segs_reg};
                div_b = cw_nz;
            end
            default:
            begin
                div_a = num_reg;
                div_b = {16'd0, mss};
            end
        endcase
    end

    wcw_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quotient (quo)
    );

    assign acc   = bw_reg * (AVERAGE_WEIGHT - 32'd1) + quo;
    assign grown = cw_nz + quo;

    assign status.action     = act_reg;
    assign status.take_rate  = take_reg;
    assign status.slow_start = cw_reg < thresh_reg;
    assign status.loss_est   = est_reg;
    assign status.div_busy   = div_busy;

    assign cwnd_out     = cwnd_out_reg;
    assign ssthresh_out = thresh_out_reg;
    assign bw_estimate  = bw_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= action;
            bytes_reg <= new_bytes;
            now_reg   <= cur_tick;
            rtt_reg   <= rtt_sample;
            segs_reg  <= new_segments;
            cw_reg    <= cwnd_in;
        end
        if (cmd.ack_pre)
        begin
            num_reg  <= bytes_reg * TICKS_PER_SECOND;
            span_reg <= span;
            take_reg <= (last_reg != '0) && (now_reg > last_reg) && (span != '0);
        end
        if (cmd.load && action == ACT_LOSS)
        begin
            num_reg <= bw_reg * minrtt_reg;
            est_reg <= (bw_reg != '0) && (minrtt_reg != '0) && (minrtt_reg != NO_RTT)
                       && (mss != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= WINDOW_RESET;
            thresh_reg     <= THRESHOLD_RESET;
            minrtt_reg     <= NO_RTT;
            bw_reg         <= BW_RESET;
            last_reg       <= '0;
            have_reg       <= 1'b0;
            cwnd_out_reg   <= '0;
            thresh_out_reg <= '0;
            bw_out_reg     <= '0;
        end
        else
        begin
            if (cmd.ack_pre)
            begin
                if (rtt_reg != '0 && rtt_reg < minrtt_reg)
                begin
                    minrtt_reg <= rtt_reg;
                end
                last_reg <= now_reg;
            end
            if (cmd.rate_done)
            begin
                bw_reg   <= have_reg ? acc / AVERAGE_WEIGHT : quo;
                have_reg <= 1'b1;
            end
            if (cmd.grow_done)
            begin
                if (cmd.grow_add)
                begin
                    window_reg <= cw_reg + {16'd0, segs_reg};
                end
                else
                begin
                    window_reg <= (grown < MIN_WINDOW) ? MIN_WINDOW : grown;
                end
            end
            if (cmd.loss_done)
            begin
                if (cmd.loss_half)
                begin
                    window_reg <= (cw_reg[31:1] < MIN_WINDOW) ? MIN_WINDOW
                                                              : {1'b0, cw_reg[31:1]};
                    thresh_reg <= (cw_reg[31:1] < MIN_WINDOW) ? MIN_WINDOW
                                                              : {1'b0, cw_reg[31:1]};
                end
                else
                begin
                    window_reg <= (quo < MIN_WINDOW) ? MIN_WINDOW : quo;
                    thresh_reg <= (quo < MIN_WINDOW) ? MIN_WINDOW : quo;
                end
            end
            if (cmd.set_done)
            begin
                window_reg <= cw_reg;
            end
            if (cmd.out_load)
            begin
                cwnd_out_reg   <= window_reg;
                thresh_out_reg <= thresh_reg;
                bw_out_reg     <= bw_reg;
            end
        end
    end

endmodule

[hdl/wcw_controller.sv]
// controller state machine sequencing one event through the datapath
// depends on wcw_pkg
`timescale 1ns / 1ps

module wcw_controller
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output wcw_pkg::dp_cmd_t    cmd,
    input  wcw_pkg::dp_status_t status
);
    import wcw_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ACK_PRE,
        ST_RATE_START,
        ST_RATE_WAIT,
        ST_GROW,
        ST_GROW_WAIT,
        ST_LOSS_WAIT,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   accept;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = DSEL_RATE;
        cmd.load    = accept;
        case (state_reg)
            ST_DISPATCH:
            begin
                if (status.action == ACT_ACK)
                begin
                    cmd.ack_pre = 1'b1;
                end
                else if (status.action == ACT_LOSS && status.loss_est)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DSEL_LOSS;
                end
                else if (status.action == ACT_LOSS)
                begin
                    cmd.loss_done = 1'b1;
                    cmd.loss_half = 1'b1;
                end
                else if (status.action == ACT_SET)
                begin
                    cmd.set_done = 1'b1;
                end
            end
            ST_RATE_START:
            begin
                cmd.div_start = status.take_rate;
                cmd.div_sel   = DSEL_RATE;
            end
            ST_RATE_WAIT:
            begin
                cmd.rate_done = !status.div_busy;
            end
            ST_GROW:
            begin
                if (status.slow_start)
                begin
                    cmd.grow_done = 1'b1;
                    cmd.grow_add  = 1'b1;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DSEL_GROW;
                end
            end
            ST_GROW_WAIT:
            begin
                cmd.grow_done = !status.div_busy;
            end
            ST_LOSS_WAIT:
            begin
                cmd.loss_done = !status.div_busy;
            end
            ST_DONE:
            begin
                cmd.out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH:
                begin
                    case (status.action)
                        ACT_ACK:    state_reg <= ST_RATE_START;
                        ACT_UPDATE: state_reg <= ST_GROW;
                        ACT_LOSS:   state_reg <= status.loss_est ? ST_LOSS_WAIT : ST_DONE;
                        default:    state_reg <= ST_DONE;
                    endcase
                end
                ST_RATE_START:
                begin
                    state_reg <= status.take_rate ? ST_RATE_WAIT : ST_GROW;
                end
                ST_RATE_WAIT:
                begin
                    if (!status.div_busy)
                    begin
                        state_reg <= ST_GROW;
                    end
                end
                ST_GROW:
                begin
                    state_reg <= status.slow_start ? ST_DONE : ST_GROW_WAIT;
                end
                ST_GROW_WAIT:
                begin
                    if (!status.div_busy)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_LOSS_WAIT:
                begin
                    if (!status.div_busy)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (cmd.out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[hdl/westwood_congestion_window_top.sv]
// an ack needs up to two divisions on one shared restoring divider (rate, then
// window growth), an update up to one, a loss with an estimate one, other
// events none; one event at a time, and a finished event waits while the
// previous result is still not taken
// top level: apb register, controller and datapath; depends on wcw_pkg, wcw_controller and wcw_datapath
`timescale 1ns / 1ps

module westwood_congestion_window_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] new_bytes,
    input  logic [63:0] cur_tick,
    input  logic [31:0] rtt_sample,
    input  logic [15:0] new_segments,
    input  logic [31:0] cwnd_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] cwnd_out,
    output logic [31:0] ssthresh_out,
    output logic [31:0] bw_estimate
);
    import wcw_pkg::*;

    logic [15:0] seg_reg;
    dp_cmd_t     cmd;
    dp_status_t  status;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, seg_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg <= SEGMENT_RESET;
        end
        else if (psel && penable && pwrite && paddr == 2'd0)
        begin
            seg_reg <= pwdata[15:0];
        end
    end

    wcw_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    wcw_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .mss          (seg_reg),
        .action       (action),
        .new_bytes    (new_bytes),
        .cur_tick     (cur_tick),
        .rtt_sample   (rtt_sample),
        .new_segments (new_segments),
        .cwnd_in      (cwnd_in),
        .cwnd_out     (cwnd_out),
        .ssthresh_out (ssthresh_out),
        .bw_estimate  (bw_estimate)
    );

endmodule

[sim/westwood_congestion_window_checker.sv]
// checker for the westwood congestion window block: predicts each event result
// and compares it with the output channel; depends on wcw_pkg
`timescale 1ns / 1ps

module westwood_congestion_window_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] new_bytes,
    input  logic [63:0] cur_tick,
    input  logic [31:0] rtt_sample,
    input  logic [15:0] new_segments,
    input  logic [31:0] cwnd_in,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] cwnd_out,
    input  logic [31:0] ssthresh_out,
    input  logic [31:0] bw_estimate,
    output int          fail_count,
    output int          pending
);
    import wcw_pkg::*;

    typedef struct packed {
        logic [31:0] cwnd;
        logic [31:0] ssthresh;
        logic [31:0] bw;
    } window_result_t;

    window_result_t expected_windows[$];

    logic [15:0] seg_bytes;
    logic [31:0] cur_window;
    logic [31:0] cur_thresh;
    logic [31:0] lowest_rtt;
    logic [31:0] bw_filter;
    logic [63:0] prev_ack_tick;
    logic        bw_valid;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic void grow(input logic [31:0] cw, input logic [15:0] segs);
        logic [31:0] w;
        w = cw;
        if (w < cur_thresh)
            w = w + segs;
        else
        begin
            if (w == 0)
                w = 1;
            w = w + 32'(segs) / w;
            if (w < MIN_WINDOW)
                w = MIN_WINDOW;
        end
        cur_window = w;
    endfunction

    function automatic window_result_t predict_event();
        window_result_t r;
        logic [31:0] span;
        logic [31:0] rate;
        logic [31:0] est;
        case (action)
            ACT_ACK:
            begin
                if (rtt_sample > 0 && rtt_sample < lowest_rtt)
                    lowest_rtt = rtt_sample;
                if (prev_ack_tick > 0 && cur_tick > prev_ack_tick)
                begin
                    span = 32'(cur_tick - prev_ack_tick);
                    if (span > 0)
                    begin
                        rate = 32'(new_bytes * TICKS_PER_SECOND) / span;
                        if (!bw_valid)
                            bw_filter = rate;
                        else
                            bw_filter = 32'(bw_filter * (AVERAGE_WEIGHT - 1) + rate)
                                        / AVERAGE_WEIGHT;
                        bw_valid = 1'b1;
                    end
                end
                prev_ack_tick = cur_tick;
                grow(cwnd_in, new_segments);
            end
            ACT_UPDATE:
                grow(cwnd_in, new_segments);
            ACT_LOSS:
            begin
                if (bw_filter > 0 && lowest_rtt > 0 && lowest_rtt != NO_RTT && seg_bytes > 0)
                    est = 32'(bw_filter * lowest_rtt) / 32'(seg_bytes);
                else
                    est = cwnd_in / 2;
                if (est < MIN_WINDOW)
                    est = MIN_WINDOW;
                cur_thresh = est;
                cur_window = est;
            end
            default:
                cur_window = cwnd_in;
        endcase
        r.cwnd = cur_window;
        r.ssthresh = cur_thresh;
        r.bw = bw_filter;
        return r;
    endfunction

    assign pending = expected_windows.size();

    always @(posedge clk or negedge rst_n)
    begin
        window_result_t want;
        if (!rst_n)
        begin
            seg_bytes <= SEGMENT_RESET;
            cur_window <= WINDOW_RESET;
            cur_thresh <= THRESHOLD_RESET;
            lowest_rtt <= NO_RTT;
            bw_filter <= BW_RESET;
            prev_ack_tick <= '0;
            bw_valid <= 1'b0;
            fail_count <= 0;
            expected_windows.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == 2'd0)
                seg_bytes = pwdata[15:0];
            if (in_valid && in_ready)
                expected_windows.push_back(predict_event());
            if (out_valid && out_ready)
            begin
                if (expected_windows.size() == 0)
                begin
                    $display("unexpected result at %0t", $realtime);
                    fail_count++;
                end
                else
                begin
                    want = expected_windows.pop_front();
                    if (cwnd_out !== want.cwnd)
                        report_mismatch("cwnd_out", cwnd_out, want.cwnd);
                    if (ssthresh_out !== want.ssthresh)
                        report_mismatch("ssthresh_out", ssthresh_out, want.ssthresh);
                    if (bw_estimate !== want.bw)
                        report_mismatch("bw_estimate", bw_estimate, want.bw);
                end
            end
        end
    end

endmodule

[sim/tb_westwood_congestion_window_top.sv]
// testbench top for the westwood congestion window block: drives apb writes and
// congestion events with random idling; depends on wcw_pkg, the top level and the checker
`timescale 1ns / 1ps

module tb_westwood_congestion_window_top;
    import wcw_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  action = ACT_SET;
    logic [31:0] new_bytes = '0;
    logic [63:0] cur_tick = '0;
    logic [31:0] rtt_sample = '0;
    logic [15:0] new_segments = '0;
    logic [31:0] cwnd_in = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] cwnd_out;
    logic [31:0] ssthresh_out;
    logic [31:0] bw_estimate;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          idle_cycles = 0;
    logic [63:0] tick_now = 64'd1;

    always #10 clk = ~clk;

    westwood_congestion_window_top dut (.*);
    westwood_congestion_window_checker checker_i (.*);

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_segment(input logic [15:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 2'd0;
        pwdata <= {16'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_event(input logic [1:0] act, input logic [31:0] bytes,
                              input logic [63:0] tick, input logic [31:0] rtt,
                              input logic [15:0] segs, input logic [31:0] cw);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        action <= act;
        new_bytes <= bytes;
        cur_tick <= tick;
        rtt_sample <= rtt;
        new_segments <= segs;
        cwnd_in <= cw;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic random_event();
        logic [1:0]  act;
        logic [31:0] cw;
        act = 2'($urandom_range(3));
        if ($urandom_range(9) < 6)
            act = ACT_ACK;
        case ($urandom_range(3))
            0: cw = $urandom;
            1: cw = $urandom_range(40);
            default: cw = $urandom_range(5000);
        endcase
        if ($urandom_range(19) == 0)
            tick_now = {$urandom, $urandom};
        else if ($urandom_range(9) == 0)
            tick_now = tick_now - $urandom_range(3);
        else
            tick_now = tick_now + $urandom_range(500);
        send_event(act, ($urandom_range(3) == 0) ? $urandom : $urandom_range(100000),
                   tick_now, ($urandom_range(4) == 0) ? 32'd0 :
                   ($urandom_range(3) == 0 ? $urandom : $urandom_range(1, 400)),
                   ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20)), cw);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // directed: no estimate loss, first ack, samples, extremes
        send_event(ACT_LOSS, 0, 0, 0, 0, 32'd3);
        send_event(ACT_LOSS, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_event(ACT_ACK, 32'd1000, 64'd100, 32'd50, 16'd3, 32'd5);
        send_event(ACT_ACK, 32'd3000, 64'd100, 32'd0, 16'd1, 32'd1);
        send_event(ACT_ACK, 32'hFFFF_FFFF, 64'd150, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
        send_event(ACT_ACK, 32'd5000, 64'h1_0000_0096, 32'd20, 16'd4, 32'd8);
        send_event(ACT_ACK, 32'd7000, 64'hFFFF_FFFF_FFFF_FFFF, 32'd30, 16'd2, 32'd9);
        send_event(ACT_ACK, 32'd10, 64'd5, 32'd1, 16'd0, 32'hFFFF_FFFF);
        send_event(ACT_LOSS, 0, 0, 0, 0, 32'd100);
        send_event(ACT_UPDATE, 0, 0, 0, 16'hFFFF, 32'd0);
        send_event(ACT_UPDATE, 0, 0, 0, 16'd7, 32'hFFFF_FFFF);
        send_event(ACT_UPDATE, 0, 0, 0, 16'd1, 32'd1);
        send_event(ACT_SET, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                   16'hFFFF, 32'hAAAA_5555);
        send_event(ACT_SET, 0, 0, 0, 0, 32'd0);
        drain();
        write_segment(16'd0);
        send_event(ACT_LOSS, 0, 0, 0, 0, 32'd50);
        drain();
        write_segment(16'hFFFF);
        send_event(ACT_LOSS, 0, 0, 0, 0, 32'd50);
        drain();
        write_segment(16'd1);
        send_event(ACT_LOSS, 0, 0, 0, 0, 32'd50);
        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            case ($urandom_range(3))
                0: write_segment(16'd1460);
                1: write_segment(16'($urandom));
                2: write_segment(16'd0);
                default: write_segment(16'd1);
            endcase
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 18 : 46) : 0;
            stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 18 : 46) : 0;
            repeat (100)
                random_event();
        end
        drain();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
